// File: rtl/contour_vertex_buffer_unit_assert.svh
// Assertion macros shared by the contour vertex buffer.
// Each property is sampled on the rising clock edge and is off during reset.
`ifndef CONTOUR_VERTEX_BUFFER_UNIT_ASSERT_SVH
`define CONTOUR_VERTEX_BUFFER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define CVB_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CVB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CVB_ASSERT_IMPL(label, ante, cons, msg)
`define CVB_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/cvb_pkg.sv
package cvb_pkg;

   // Vertex store geometry.
   localparam int DEPTH = 64;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   // Operation codes of one request transfer.
   typedef enum logic [1:0] {
      OP_RESET,
      OP_APPEND,
      OP_LOOKUP,
      OP_EVICT
   } op_type;

   // One stored vertex: four-axis pose and cumulative arc position.
   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] u;
      logic [31:0] v;
      logic [31:0] arc;
   } vertex_type;

   // Commands of the shared arithmetic unit.
   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_SQRT,
      ALU_DIV
   } alu_kind_type;

   typedef struct packed {
      logic         start;
      alu_kind_type kind;
   } alu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_sts_type;

   // Physical slot of the logical entry i of the ring that starts at oldest.
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] oldest,
                                          input logic [CW-1:0] i);
      logic [CW:0] sum;
      sum = (CW+1)'(oldest) + (CW+1)'(i);
      if (sum >= (CW+1)'(DEPTH)) begin
         sum = sum - (CW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   // One axis of a vertex pose.
   function automatic logic [31:0] vtx_axis(input vertex_type e, input logic [1:0] k);
      logic [31:0] r;
      unique case (k)
         2'd0:    r = e.x;
         2'd1:    r = e.y;
         2'd2:    r = e.u;
         default: r = e.v;
      endcase
      return r;
   endfunction

   // Signed difference b - a of two Q16.16 values; sign bit at the top.
   function automatic logic [32:0] sdiff(input logic [31:0] b, input logic [31:0] a);
      return {b[31], b} - {a[31], a};
   endfunction

   // Magnitude of a 33-bit signed difference of two 32-bit values.
   function automatic logic [31:0] dmag(input logic [32:0] d);
      logic [32:0] n;
      n = -d;
      return d[32] ? n[31:0] : d[31:0];
   endfunction

endpackage

// File: rtl/cvb_req_if.sv
interface cvb_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_u;
   logic signed [31:0] pos_v;
   logic [31:0]        arc_position;

   modport source (output valid, output operation, output pos_x, output pos_y,
                   output pos_u, output pos_v, output arc_position, input ready);
   modport sink   (input valid, input operation, input pos_x, input pos_y,
                   input pos_u, input pos_v, input arc_position, output ready);
endinterface

// File: rtl/cvb_rsp_if.sv
interface cvb_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_u;
   logic signed [31:0] out_v;
   logic [31:0]        total_length;
   logic [6:0]         vertex_count;
   logic               buffer_empty;

   modport source (output valid, output out_x, output out_y, output out_u,
                   output out_v, output total_length, output vertex_count,
                   output buffer_empty, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_u,
                   input out_v, input total_length, input vertex_count,
                   input buffer_empty, output ready);
endinterface

// File: rtl/cvb_ram.sv
module cvb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: rtl/cvb_alu.sv
module cvb_alu (
   input  logic                clock,
   input  logic                reset,
   input  cvb_pkg::alu_cmd_type cmd,
   input  logic [31:0]         opa,
   input  logic [31:0]         opb,
   input  logic [63:0]         rad,
   input  logic [31:0]         dvs,
   output cvb_pkg::alu_sts_type sts,
   output logic [63:0]         result
);
   import cvb_pkg::*;

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   alu_kind_type kind_ff, kind_in;
   logic [4:0]   cnt_ff, cnt_in;
   logic [63:0]  work_ff, work_in;
   logic [34:0]  rem_ff, rem_in;
   logic [31:0]  quo_ff, quo_in;
   logic [63:0]  prod_ff, prod_in;
   logic [31:0]  dvs_ff, dvs_in;

   logic [34:0]  rem_sh;
   logic [34:0]  trial;
   logic         fits;

   // Shared restoring step: square root takes two bits, division one bit per cycle.
   always_comb begin
      if (kind_ff == ALU_SQRT) begin
         rem_sh = {rem_ff[32:0], work_ff[63:62]};
         trial  = {1'b0, quo_ff, 2'b01};
      end else begin
         rem_sh = {2'b00, rem_ff[31:0], work_ff[63]};
         trial  = {3'b000, dvs_ff};
      end
      fits = rem_sh >= trial;
   end

   // Next-state logic.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      kind_in = kind_ff;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      prod_in = prod_ff;
      dvs_in  = dvs_ff;
      if (cmd.start) begin
         kind_in = cmd.kind;
         cnt_in  = 5'd31;
         quo_in  = '0;
         unique case (cmd.kind)
            ALU_MUL: begin
               prod_in = opa * opb;
               done_in = 1'b1;
            end
            ALU_SQRT: begin
               work_in = rad;
               rem_in  = '0;
               busy_in = 1'b1;
            end
            ALU_DIV: begin
               work_in = {rad[31:0], 32'd0};
               rem_in  = {3'b000, rad[63:32]};
               dvs_in  = dvs;
               busy_in = 1'b1;
            end
            default: begin
               done_in = 1'b1;
            end
         endcase
      end else if (busy_ff) begin
         rem_in  = fits ? rem_sh - trial : rem_sh;
         quo_in  = {quo_ff[30:0], fits};
         work_in = (kind_ff == ALU_SQRT) ? {work_ff[61:0], 2'b00} : {work_ff[62:0], 1'b0};
         cnt_in  = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      kind_ff <= kind_in;
      cnt_ff  <= cnt_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      prod_ff <= prod_in;
      dvs_ff  <= dvs_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = (kind_ff == ALU_MUL) ? prod_ff : {32'd0, quo_ff};

endmodule

// File: rtl/contour_vertex_buffer_unit.sv
// Contour vertex buffer: a ring of up to 64 four-axis vertices with cumulative
// arc positions, taking one operation at a time and returning one result for
// each. Operations are reset to a start pose, append (chord measured in xy, else
// uv, vertex dropped below min_segment_length, oldest overwritten when full),
// lookup by arc position with linear interpolation, and evict below a floor.
// All operations share the one RAM read port and the 32-step multiply/root/divide
// unit. Append measures one or two chords; lookup clamps at the ends, else runs a
// binary search and then interpolates the four axes one after another; evict
// scans the vertices from the oldest. The vertex store needs no clearing pass
// after reset.
`include "contour_vertex_buffer_unit_assert.svh"

module contour_vertex_buffer_unit (
   input logic        clock,
   input logic        reset,
   cvb_req_if.sink    req_if,
   cvb_rsp_if.source  rsp_if,
   input logic        csr_wr_en,
   input logic [15:0] csr_wr_data
);
   import cvb_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_APP_CAP,
      ST_APP_MUL1,
      ST_APP_MUL2,
      ST_APP_SUM,
      ST_APP_SQRT,
      ST_APP_DEC,
      ST_LK_FRONT,
      ST_LK_BACK,
      ST_LK_LOOP,
      ST_LK_CMP,
      ST_LK_RLO,
      ST_LK_RHI,
      ST_LK_SEG,
      ST_LK_MUL,
      ST_LK_DIV,
      ST_LK_ACC,
      ST_EV_CMP,
      ST_EV_APPLY,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     oldest_ff, oldest_in;
   logic [CW-1:0]     held_ff, held_in;
   logic [31:0]       total_ff, total_in;
   logic [15:0]       min_len_ff, min_len_in;
   vertex_type        pose_ff, pose_in;
   logic              was_empty_ff, was_empty_in;
   vertex_type        lo_ent_ff, lo_ent_in;
   vertex_type        hi_ent_ff, hi_ent_in;
   logic              pass_ff, pass_in;
   logic [63:0]       s1_ff, s1_in;
   logic [31:0]       ds_ff, ds_in;
   logic [CW-1:0]     lo_ff, lo_in;
   logic [CW-1:0]     hi_ff, hi_in;
   logic [CW-1:0]     mid_ff, mid_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     keep_ff, keep_in;
   logic [31:0]       seg_ff, seg_in;
   logic [31:0]       num_ff, num_in;
   logic [1:0]        axis_ff, axis_in;
   logic [3:0][31:0]  out_ff, out_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [3:0][31:0]  rsp_pose_ff, rsp_pose_in;
   logic [31:0]       rsp_total_ff, rsp_total_in;
   logic [CW-1:0]     rsp_count_ff, rsp_count_in;
   logic              rsp_empty_ff, rsp_empty_in;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   vertex_type        ram_wr_data;
   logic [AW-1:0]     ram_rd_addr;
   logic [$bits(vertex_type)-1:0] ram_rd_data;
   vertex_type        rd_vtx;

   alu_cmd_type       alu_cmd;
   alu_sts_type       alu_sts;
   logic [31:0]       alu_opa;
   logic [31:0]       alu_opb;
   logic [63:0]       alu_rad;
   logic [63:0]       alu_res;

   logic              req_xfer;
   logic [AW-1:0]     newest_addr;
   logic [32:0]       chord_d1;
   logic [32:0]       chord_d2;
   logic [32:0]       lerp_d;
   logic [64:0]       sq_sum;
   logic [32:0]       new_arc;
   logic [32:0]       lk_num;
   logic [CW:0]       mid_sum;
   logic [CW-1:0]     idx_next;
   logic [31:0]       lerp_a;

   // Vertex store.
   cvb_ram #(
      .WIDTH ($bits(vertex_type)),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Shared multiply, square root and divide unit.
   cvb_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .opa    (alu_opa),
      .opb    (alu_opb),
      .rad    (alu_rad),
      .dvs    (seg_ff),
      .sts    (alu_sts),
      .result (alu_res)
   );

   assign rd_vtx   = vertex_type'(ram_rd_data);
   assign req_xfer = req_if.valid && req_if.ready;

   // Datapath helpers for the chord and the interpolation.
   always_comb begin
      newest_addr = phys(oldest_ff, held_ff - CW'(1));
      chord_d1    = pass_ff ? sdiff(pose_ff.u, lo_ent_ff.u) : sdiff(pose_ff.x, lo_ent_ff.x);
      chord_d2    = pass_ff ? sdiff(pose_ff.v, lo_ent_ff.v) : sdiff(pose_ff.y, lo_ent_ff.y);
      lerp_a      = vtx_axis(lo_ent_ff, axis_ff);
      lerp_d      = sdiff(vtx_axis(hi_ent_ff, axis_ff), lerp_a);
      sq_sum      = {1'b0, s1_ff} + {1'b0, alu_res};
      new_arc     = {1'b0, lo_ent_ff.arc} + {1'b0, ds_ff};
      lk_num      = {1'b0, pose_ff.arc} - {1'b0, lo_ent_ff.arc};
      mid_sum     = {1'b0, lo_ff} + {1'b0, hi_ff};
      idx_next    = idx_ff + CW'(1);
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      oldest_in    = oldest_ff;
      held_in      = held_ff;
      total_in     = total_ff;
      min_len_in   = csr_wr_en ? csr_wr_data : min_len_ff;
      pose_in      = pose_ff;
      was_empty_in = was_empty_ff;
      lo_ent_in    = lo_ent_ff;
      hi_ent_in    = hi_ent_ff;
      pass_in      = pass_ff;
      s1_in        = s1_ff;
      ds_in        = ds_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      idx_in       = idx_ff;
      keep_in      = keep_ff;
      seg_in       = seg_ff;
      num_in       = num_ff;
      axis_in      = axis_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_pose_in  = rsp_pose_ff;
      rsp_total_in = rsp_total_ff;
      rsp_count_in = rsp_count_ff;
      rsp_empty_in = rsp_empty_ff;

      ram_wr_en    = 1'b0;
      ram_wr_addr  = oldest_ff;
      ram_wr_data  = pose_ff;
      ram_rd_addr  = oldest_ff;
      alu_cmd      = '{start: 1'b0, kind: ALU_MUL};
      alu_opa      = dmag(chord_d1);
      alu_opb      = dmag(chord_d1);
      alu_rad      = sq_sum[63:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               pose_in      = '{x: req_if.pos_x, y: req_if.pos_y, u: req_if.pos_u,
                                v: req_if.pos_v, arc: req_if.arc_position};
               was_empty_in = held_ff == '0;
               out_in       = '0;
               pass_in      = 1'b0;
               state_in     = ST_DONE;
               unique case (op_type'(req_if.operation))
                  OP_RESET: begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = '0;
                     ram_wr_data = pose_in;
                     oldest_in   = '0;
                     held_in     = CW'(1);
                     total_in    = req_if.arc_position;
                  end
                  OP_APPEND: begin
                     if (held_ff == '0) begin
                        ram_wr_en       = 1'b1;
                        ram_wr_addr     = oldest_ff;
                        ram_wr_data     = pose_in;
                        ram_wr_data.arc = '0;
                        held_in         = CW'(1);
                        total_in        = '0;
                     end else begin
                        ram_rd_addr = newest_addr;
                        state_in    = ST_APP_CAP;
                     end
                  end
                  OP_LOOKUP: begin
                     if (held_ff != '0) begin
                        ram_rd_addr = oldest_ff;
                        state_in    = ST_LK_FRONT;
                     end
                  end
                  OP_EVICT: begin
                     if (held_ff > CW'(1)) begin
                        ram_rd_addr = oldest_ff;
                        idx_in      = '0;
                        keep_in     = '0;
                        state_in    = ST_EV_CMP;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // Append: keep the newest vertex, then square and sum the chord axes and take the root.
         ST_APP_CAP: begin
            lo_ent_in = rd_vtx;
            state_in  = ST_APP_MUL1;
         end
         ST_APP_MUL1: begin
            alu_cmd  = '{start: 1'b1, kind: ALU_MUL};
            state_in = ST_APP_MUL2;
         end
         ST_APP_MUL2: begin
            if (alu_sts.done) begin
               s1_in    = alu_res;
               alu_opa  = dmag(chord_d2);
               alu_opb  = dmag(chord_d2);
               alu_cmd  = '{start: 1'b1, kind: ALU_MUL};
               state_in = ST_APP_SUM;
            end
         end
         ST_APP_SUM: begin
            if (alu_sts.done) begin
               if (sq_sum[64]) begin
                  ds_in    = '1;
                  state_in = ST_APP_DEC;
               end else begin
                  alu_cmd  = '{start: 1'b1, kind: ALU_SQRT};
                  state_in = ST_APP_SQRT;
               end
            end
         end
         ST_APP_SQRT: begin
            if (alu_sts.done) begin
               ds_in    = alu_res[31:0];
               state_in = ST_APP_DEC;
            end
         end
         ST_APP_DEC: begin
            // Fall back to the uv chord once, then accept or drop the vertex.
            if (ds_ff < {16'd0, min_len_ff}) begin
               if (!pass_ff) begin
                  pass_in  = 1'b1;
                  state_in = ST_APP_MUL1;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               ram_wr_en       = 1'b1;
               ram_wr_data.arc = new_arc[32] ? '1 : new_arc[31:0];
               total_in        = ram_wr_data.arc;
               if (held_ff >= CW'(DEPTH)) begin
                  ram_wr_addr = oldest_ff;
                  oldest_in   = phys(oldest_ff, CW'(1));
               end else begin
                  ram_wr_addr = phys(oldest_ff, held_ff);
                  held_in     = held_ff + CW'(1);
               end
               state_in = ST_DONE;
            end
         end

         // Lookup: clamp at both ends, then binary search.
         ST_LK_FRONT: begin
            if (pose_ff.arc <= rd_vtx.arc) begin
               out_in   = {rd_vtx.v, rd_vtx.u, rd_vtx.y, rd_vtx.x};
               state_in = ST_DONE;
            end else begin
               ram_rd_addr = newest_addr;
               state_in    = ST_LK_BACK;
            end
         end
         ST_LK_BACK: begin
            if (pose_ff.arc >= rd_vtx.arc) begin
               out_in   = {rd_vtx.v, rd_vtx.u, rd_vtx.y, rd_vtx.x};
               state_in = ST_DONE;
            end else begin
               lo_in    = '0;
               hi_in    = held_ff - CW'(1);
               state_in = ST_LK_LOOP;
            end
         end
         ST_LK_LOOP: begin
            if (hi_ff - lo_ff > CW'(1)) begin
               mid_in      = mid_sum[CW:1];
               ram_rd_addr = phys(oldest_ff, mid_sum[CW:1]);
               state_in    = ST_LK_CMP;
            end else begin
               ram_rd_addr = phys(oldest_ff, lo_ff);
               state_in    = ST_LK_RLO;
            end
         end
         ST_LK_CMP: begin
            if (rd_vtx.arc <= pose_ff.arc) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff;
            end
            state_in = ST_LK_LOOP;
         end
         ST_LK_RLO: begin
            lo_ent_in   = rd_vtx;
            ram_rd_addr = phys(oldest_ff, hi_ff);
            state_in    = ST_LK_RHI;
         end
         ST_LK_RHI: begin
            hi_ent_in = rd_vtx;
            state_in  = ST_LK_SEG;
         end
         ST_LK_SEG: begin
            if (hi_ent_ff.arc <= lo_ent_ff.arc) begin
               out_in   = {lo_ent_ff.v, lo_ent_ff.u, lo_ent_ff.y, lo_ent_ff.x};
               state_in = ST_DONE;
            end else begin
               seg_in = hi_ent_ff.arc - lo_ent_ff.arc;
               // A position below the lower vertex or beyond the upper one counts as the whole segment.
               if (lk_num[32] || (lk_num[31:0] > seg_in)) begin
                  num_in = seg_in;
               end else begin
                  num_in = lk_num[31:0];
               end
               axis_in  = '0;
               state_in = ST_LK_MUL;
            end
         end
         ST_LK_MUL: begin
            alu_opa  = dmag(lerp_d);
            alu_opb  = num_ff;
            alu_cmd  = '{start: 1'b1, kind: ALU_MUL};
            state_in = ST_LK_DIV;
         end
         ST_LK_DIV: begin
            if (alu_sts.done) begin
               alu_rad  = alu_res;
               alu_cmd  = '{start: 1'b1, kind: ALU_DIV};
               state_in = ST_LK_ACC;
            end
         end
         ST_LK_ACC: begin
            // Step from the lower vertex toward the upper one, truncated toward the lower one.
            if (alu_sts.done) begin
               out_in[axis_ff] = lerp_d[32] ? lerp_a - alu_res[31:0]
                                            : lerp_a + alu_res[31:0];
               axis_in = axis_ff + 2'd1;
               if (axis_ff == 2'd3) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_LK_MUL;
               end
            end
         end

         // Evict: scan from the oldest vertex for the last one at or below the floor.
         ST_EV_CMP: begin
            if (rd_vtx.arc <= pose_ff.arc) begin
               keep_in = idx_ff;
               if (idx_next < held_ff) begin
                  idx_in      = idx_next;
                  ram_rd_addr = phys(oldest_ff, idx_next);
               end else begin
                  state_in = ST_EV_APPLY;
               end
            end else begin
               state_in = ST_EV_APPLY;
            end
         end
         ST_EV_APPLY: begin
            if (keep_ff != '0) begin
               oldest_in = phys(oldest_ff, keep_ff);
               held_in   = held_ff - keep_ff;
            end
            state_in = ST_DONE;
         end

         // Hand the result to the output register once it is free.
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pose_in  = out_ff;
               rsp_total_in = total_ff;
               rsp_count_in = held_ff;
               rsp_empty_in = was_empty_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oldest_ff    <= '0;
         held_ff      <= '0;
         total_ff     <= '0;
         min_len_ff   <= 16'd16;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         held_ff      <= held_in;
         total_ff     <= total_in;
         min_len_ff   <= min_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pose_ff      <= pose_in;
      was_empty_ff <= was_empty_in;
      lo_ent_ff    <= lo_ent_in;
      hi_ent_ff    <= hi_ent_in;
      pass_ff      <= pass_in;
      s1_ff        <= s1_in;
      ds_ff        <= ds_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      idx_ff       <= idx_in;
      keep_ff      <= keep_in;
      seg_ff       <= seg_in;
      num_ff       <= num_in;
      axis_ff      <= axis_in;
      out_ff       <= out_in;
      rsp_pose_ff  <= rsp_pose_in;
      rsp_total_ff <= rsp_total_in;
      rsp_count_ff <= rsp_count_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   // Channel outputs.
   assign req_if.ready        = state_ff == ST_IDLE;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.out_x        = rsp_pose_ff[0];
   assign rsp_if.out_y        = rsp_pose_ff[1];
   assign rsp_if.out_u        = rsp_pose_ff[2];
   assign rsp_if.out_v        = rsp_pose_ff[3];
   assign rsp_if.total_length = rsp_total_ff;
   assign rsp_if.vertex_count = 7'(rsp_count_ff);
   assign rsp_if.buffer_empty = rsp_empty_ff;

   // Checks on the sequencer and the ring bookkeeping.
   `CVB_ASSERT_IMPL(a_held_bound, 1'b1, held_ff <= CW'(DEPTH), "held count above depth")
   `CVB_ASSERT_IMPL(a_empty_total, held_ff == '0, total_ff == '0, "empty buffer with length")
   `CVB_ASSERT_IMPL(a_idle_alu, state_ff == ST_IDLE, !alu_sts.busy, "arithmetic busy in idle")
   `CVB_ASSERT_NEXT(a_busy_after_xfer, req_xfer, !req_if.ready, "ready right after a transfer")

endmodule
